@@ src/sfcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared types, constants and the crc-8 byte update for the sensor frame
// checker and converter.
// ----------------------------------------------------------------------------
package sfcc_pkg;

  // configuration register indexes
  localparam logic REG_CRC_INIT = 1'b0;
  localparam logic REG_CRC_POLY = 1'b1;

  localparam logic [7:0] CRC_INIT_RESET = 8'hFF;
  localparam logic [7:0] CRC_POLY_RESET = 8'h31;

  // status bits in the two low bits of each word are dropped before scaling
  localparam logic [15:0] STATUS_MASK = 16'hFFFC;

  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd12500;
  localparam logic [14:0] HUM_OFFSET  = 15'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;

  // place of the incoming byte within the six-byte reply
  typedef enum logic [2:0] {
    BYTE_A_HI,
    BYTE_A_LO,
    BYTE_A_CRC,
    BYTE_B_HI,
    BYTE_B_LO,
    BYTE_B_CRC
  } byte_pos_t;

  // one complete reply, handed from the frame stage to the converter
  typedef struct packed {
    logic        crc_ok;
    logic [31:0] words;
  } frame_t;

  // msb-first crc-8, no reflection, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/sfcc_frame.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_frame
// Byte tracker: runs the per-word crc, collects both words and registers
// one complete reply on its sixth byte.
// ----------------------------------------------------------------------------
module sfcc_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              frame_start,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        crc_init,
  input  logic [7:0]        crc_poly,
  output logic              frm_valid,
  output sfcc_pkg::frame_t  frm,
  input  logic              frm_take
);

  sfcc_pkg::byte_pos_t pos;
  sfcc_pkg::byte_pos_t pos_cur;
  sfcc_pkg::byte_pos_t pos_next;

  logic [7:0]  running_crc;
  logic [7:0]  crc_start;
  logic [7:0]  crc_new;
  logic [15:0] first_word;
  logic [7:0]  second_word_high;
  logic [7:0]  second_word_low;
  logic        first_crc_matched;
  logic        accept;

  assign req_ready = !frm_valid || frm_take;
  assign accept    = req_valid && req_ready;

  // a frame start marker always restarts at the first byte
  assign pos_cur   = frame_start ? sfcc_pkg::BYTE_A_HI : pos;
  assign crc_start = (pos_cur == sfcc_pkg::BYTE_A_HI || pos_cur == sfcc_pkg::BYTE_B_HI)
                     ? crc_init : running_crc;
  assign crc_new   = sfcc_pkg::crc8_byte(crc_start, rx_byte, crc_poly);

  always_comb begin
    pos_next = pos;
    if (accept) begin
      unique case (pos_cur)
        sfcc_pkg::BYTE_A_HI:  pos_next = sfcc_pkg::BYTE_A_LO;
        sfcc_pkg::BYTE_A_LO:  pos_next = sfcc_pkg::BYTE_A_CRC;
        sfcc_pkg::BYTE_A_CRC: pos_next = sfcc_pkg::BYTE_B_HI;
        sfcc_pkg::BYTE_B_HI:  pos_next = sfcc_pkg::BYTE_B_LO;
        sfcc_pkg::BYTE_B_LO:  pos_next = sfcc_pkg::BYTE_B_CRC;
        default:              pos_next = sfcc_pkg::BYTE_A_HI;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= sfcc_pkg::BYTE_A_HI;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (accept && pos_cur == sfcc_pkg::BYTE_B_CRC) begin
      frm_valid <= 1'b1;
    end else if (frm_take) begin
      frm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (pos_cur)
        sfcc_pkg::BYTE_A_HI: begin
          running_crc       <= crc_new;
          first_word[15:8]  <= rx_byte;
        end
        sfcc_pkg::BYTE_A_LO: begin
          running_crc       <= crc_new;
          first_word[7:0]   <= rx_byte;
        end
        sfcc_pkg::BYTE_A_CRC: begin
          first_crc_matched <= (running_crc == rx_byte);
        end
        sfcc_pkg::BYTE_B_HI: begin
          running_crc       <= crc_new;
          second_word_high  <= rx_byte;
        end
        sfcc_pkg::BYTE_B_LO: begin
          running_crc       <= crc_new;
          second_word_low   <= rx_byte;
        end
        default: begin
          frm.crc_ok <= first_crc_matched && (running_crc == rx_byte);
          frm.words  <= {first_word, second_word_high, second_word_low};
        end
      endcase
    end
  end

endmodule

@@ src/sfcc_convert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_convert
// Two-stage converter: constant multiply, then divide by 65535 through the
// reciprocal identity, offset and humidity clamp into the result register.
// ----------------------------------------------------------------------------
module sfcc_convert (
  input  logic              clk,
  input  logic              rst,
  input  logic              frm_valid,
  input  sfcc_pkg::frame_t  frm,
  output logic              frm_take,
  output logic              res_valid,
  input  logic              res_ready,
  output logic              crc_ok,
  output logic [31:0]       raw_words,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]       humidity_centi
);

  logic             mul_valid;
  sfcc_pkg::frame_t mul_frm;
  logic [30:0]      t_prod;
  logic [29:0]      h_prod;
  logic             mul_ready;
  logic             res_free;

  logic [31:0]        t_sum;
  logic [15:0]        t_quo;
  logic signed [15:0] t_val;
  logic [30:0]        h_sum;
  logic [14:0]        h_quo;
  logic [14:0]        h_diff;
  logic [13:0]        h_val;

  assign res_free  = !res_valid || res_ready;
  assign mul_ready = !mul_valid || res_free;
  assign frm_take  = frm_valid && mul_ready;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_take) begin
      mul_frm <= frm;
      t_prod  <= 31'(sfcc_pkg::TEMP_SPAN) * 31'(frm.words[31:16] & sfcc_pkg::STATUS_MASK);
      h_prod  <= 30'(sfcc_pkg::HUM_SPAN) * 30'(frm.words[15:0] & sfcc_pkg::STATUS_MASK);
    end
  end

  // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 while the quotient stays below 2^16
  always_comb begin
    t_sum  = {1'b0, t_prod} + 32'(t_prod[30:16]) + 32'd1;
    t_quo  = t_sum[31:16];
    t_val  = $signed(t_quo) - $signed(sfcc_pkg::TEMP_OFFSET);
    h_sum  = {1'b0, h_prod} + 31'(h_prod[29:16]) + 31'd1;
    h_quo  = h_sum[30:16];
    h_diff = h_quo - sfcc_pkg::HUM_OFFSET;
    if (h_quo < sfcc_pkg::HUM_OFFSET) begin
      h_val = '0;
    end else if (h_diff > 15'(sfcc_pkg::HUM_MAX)) begin
      h_val = sfcc_pkg::HUM_MAX;
    end else begin
      h_val = h_diff[13:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid && res_free) begin
      crc_ok            <= mul_frm.crc_ok;
      raw_words         <= mul_frm.words;
      temperature_centi <= t_val[14:0];
      humidity_centi    <= h_val;
    end
  end

endmodule

@@ src/sensor_frame_crc_check_and_convert_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_and_convert_unit
// Checks the two crc-8 bytes of a six-byte sensor reply and converts the
// words into temperature and humidity in hundredths.
// ----------------------------------------------------------------------------
// one byte request per cycle sustained; a stalled result backs up the pipe
// result passes through the frame reg (loaded at the edge that takes the
// sixth byte), then multiply reg, then result reg; the 16x15 constant
// multiply sets the stage split
// reset clears byte position and all valid flags; crc start value 0xff and
// polynomial 0x31 after reset, no clearing pass

module sensor_frame_crc_check_and_convert_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               frame_start,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               crc_ok,
  output logic [31:0]        raw_words,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi
);

  logic [7:0]       crc_init;
  logic [7:0]       crc_poly;
  logic             frm_valid;
  logic             frm_take;
  sfcc_pkg::frame_t frm;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_init <= sfcc_pkg::CRC_INIT_RESET;
      crc_poly <= sfcc_pkg::CRC_POLY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfcc_pkg::REG_CRC_INIT: crc_init <= cfg_data;
        sfcc_pkg::REG_CRC_POLY: crc_poly <= cfg_data;
        default: ;
      endcase
    end
  end

  sfcc_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .frame_start (frame_start),
    .rx_byte     (rx_byte),
    .crc_init    (crc_init),
    .crc_poly    (crc_poly),
    .frm_valid   (frm_valid),
    .frm         (frm),
    .frm_take    (frm_take)
  );

  sfcc_convert u_convert (
    .clk               (clk),
    .rst               (rst),
    .frm_valid         (frm_valid),
    .frm               (frm),
    .frm_take          (frm_take),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .crc_ok            (crc_ok),
    .raw_words         (raw_words),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi)
  );

  // humidity is clamped
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> humidity_centi <= sfcc_pkg::HUM_MAX)
    else $error("humidity above clamp");

  // temperature stays inside the scaled span
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd12999))
    else $error("temperature out of span");

  // request side only stalls when every stage holds a reply and the result waits
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (frm_valid && res_valid && !res_ready))
    else $error("request stalled with room in the pipe");

endmodule
